// File: rtl/skq_pkg.sv
// Package for the sorted key queue: sizes, opcodes, status codes, controller
// states, command and status structs, and key and slot helper functions.
// No dependencies.
package skq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int BOARD_SIZE  = 256;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 23;
  localparam int SQUARE_W = 8;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 6;
  localparam int KEY_W    = 31;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_SORT   = 3'd3,
    OP_POP    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_SORT_RD,
    S_SORT_LD,
    S_INS_CHK,
    S_INS_CMP,
    S_INS_END,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    clr;
    logic    app_wr;
    logic    ins_start;
    logic    sort_start;
    logic    pop_rd;
    logic    pop_take;
    logic    sort_rd;
    logic    sort_ld;
    logic    chk_wr;
    logic    chk_rd;
    logic    cmp_shift;
    logic    cmp_place;
    logic    count_inc;
    logic    i_inc;
    logic    st_load;
    status_t st;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            few;
    logic            j_zero;
    logic            cur_lt;
    logic            sort_more;
    logic            out_free;
  } dp_stat_t;

  function automatic logic [KEY_W-1:0] make_key(input logic [VALUE_W-1:0] value,
                                                input logic [SQUARE_W-1:0] square);
    logic [KEY_W-1:0] k;
    k = KEY_W'(value) * KEY_W'(BOARD_SIZE) + KEY_W'(square);
    return k;
  endfunction

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(front) + SUM_W'(pos);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

// File: rtl/skq_if.sv
// Channel interfaces for the sorted key queue: input items and results.
// Depends on skq_pkg.
interface skq_in_if import skq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [VALUE_W-1:0]  item_value;
  logic [SQUARE_W-1:0] item_square;

  modport source (output valid, output opcode, output item_value, output item_square,
                  input ready);
  modport sink (input valid, input opcode, input item_value, input item_square,
                output ready);
endinterface

interface skq_out_if import skq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  popped_value;
  logic [SQUARE_W-1:0] popped_square;
  logic                queue_empty;
  logic [ENTRY_W-1:0]  entry_count;

  modport source (output valid, output status, output popped_value, output popped_square,
                  output queue_empty, output entry_count, input ready);
  modport sink (input valid, input status, input popped_value, input popped_square,
                input queue_empty, input entry_count, output ready);
endinterface

// File: rtl/sorted_key_queue.sv
// Top level of the sorted key queue: joins controller and datapath.
// Depends on skq_pkg, skq_if, skq_ram, skq_ctrl, skq_dp.
//
//   channel  dir  transfer when        payload
//   in_ch    in   valid & ready        opcode, item_value, item_square
//   out_ch   out  valid & ready        status, popped_value, popped_square,
//                                      queue_empty, entry_count
//
// Clear, append, full, unused and sort on fewer than two entries pass through
// idle, decode and finish; pop adds a wait step for the store read. Insert checks
// and compares for each entry moved back, then places the key and counts it. Sort
// reads and loads each entry after the first and inserts it the same way. The key
// store's single read port is why entries move back one at a time.
// Reset clears front and count; the store needs no clearing.
// One item is worked at a time; a new item is taken while a result waits,
// and the block holds in its last step until out_ch takes the earlier result.
module sorted_key_queue import skq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  skq_in_if.sink    in_ch,
  skq_out_if.source out_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  skq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_ch.opcode),
    .in_item_value     (in_ch.item_value),
    .in_item_square    (in_ch.item_square),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_popped_value  (out_ch.popped_value),
    .out_popped_square (out_ch.popped_square),
    .out_queue_empty   (out_ch.queue_empty),
    .out_entry_count   (out_ch.entry_count)
  );
endmodule

// File: rtl/skq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/skq_ctrl.sv
// Controller for the sorted key queue: sequences clear, append, insert,
// sort and pop over the datapath. Depends on skq_pkg.
module skq_ctrl import skq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st    = ST_OK;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (stat.op)
          OP_CLEAR: begin
            cmd.clr = 1'b1;
          end
          OP_APPEND: begin
            if (stat.full) begin
              cmd.st_load = 1'b1;
              cmd.st      = ST_FULL;
            end else begin
              cmd.app_wr    = 1'b1;
              cmd.count_inc = 1'b1;
            end
          end
          OP_INSERT: begin
            if (stat.full) begin
              cmd.st_load = 1'b1;
              cmd.st      = ST_FULL;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = S_INS_CHK;
            end
          end
          OP_SORT: begin
            if (!stat.few) begin
              cmd.sort_start = 1'b1;
              state_nxt      = S_SORT_RD;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.st_load = 1'b1;
              cmd.st      = ST_EMPTY;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_SORT_RD: begin
        cmd.sort_rd = 1'b1;
        state_nxt   = S_SORT_LD;
      end
      S_SORT_LD: begin
        cmd.sort_ld = 1'b1;
        state_nxt   = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (stat.j_zero) begin
          cmd.chk_wr = 1'b1;
          state_nxt  = S_INS_END;
        end else begin
          cmd.chk_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.cur_lt) begin
          cmd.cmp_shift = 1'b1;
          state_nxt     = S_INS_CHK;
        end else begin
          cmd.cmp_place = 1'b1;
          state_nxt     = S_INS_END;
        end
      end
      S_INS_END: begin
        if (stat.op == OP_SORT) begin
          cmd.i_inc = 1'b1;
          state_nxt = stat.sort_more ? S_SORT_RD : S_FINISH;
        end else begin
          cmd.count_inc = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// File: rtl/skq_dp.sv
// Datapath for the sorted key queue: key store, front and count registers,
// insertion registers and the result register. Depends on skq_pkg, skq_ram.
module skq_dp import skq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [VALUE_W-1:0]   in_item_value,
  input  logic [SQUARE_W-1:0]  in_item_square,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [VALUE_W-1:0]   out_popped_value,
  output logic [SQUARE_W-1:0]  out_popped_square,
  output logic                 out_queue_empty,
  output logic [ENTRY_W-1:0]   out_entry_count
);
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    cur_r;
  logic [CNT_W-1:0]    j_r;
  logic [CNT_W-1:0]    i_r;
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    front_r;
  status_t             st_r;
  logic [VALUE_W-1:0]  pv_r;
  logic [SQUARE_W-1:0] ps_r;
  logic                out_valid_r;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [KEY_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]    j_prev;

  assign j_prev = j_r - CNT_W'(1);

  assign ram_we    = cmd.app_wr | cmd.chk_wr | cmd.cmp_shift | cmd.cmp_place;
  assign ram_waddr = cmd.app_wr ? slot_of(front_r, count_r) : slot_of(front_r, j_r);
  assign ram_wdata = cmd.app_wr ? key_r : (cmd.cmp_shift ? ram_rdata : cur_r);
  assign ram_re    = cmd.pop_rd | cmd.sort_rd | cmd.chk_rd;

  always_comb begin
    ram_raddr = slot_of(front_r, j_prev);
    if (cmd.pop_rd) begin
      ram_raddr = front_r;
    end else if (cmd.sort_rd) begin
      ram_raddr = slot_of(front_r, i_r);
    end
  end

  skq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_opcode;
      key_r <= make_key(in_item_value, in_item_square);
      st_r  <= ST_OK;
      pv_r  <= '0;
      ps_r  <= '0;
    end
    if (cmd.st_load) begin
      st_r <= cmd.st;
    end
    if (cmd.pop_take) begin
      pv_r <= VALUE_W'(ram_rdata / BOARD_SIZE);
      ps_r <= SQUARE_W'(ram_rdata % BOARD_SIZE);
    end
    if (cmd.ins_start) begin
      cur_r <= key_r;
      j_r   <= count_r;
    end
    if (cmd.sort_start) begin
      i_r <= CNT_W'(1);
    end
    if (cmd.sort_rd) begin
      j_r <= i_r;
    end
    if (cmd.sort_ld) begin
      cur_r <= ram_rdata;
    end
    if (cmd.cmp_shift) begin
      j_r <= j_prev;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_status        <= st_r;
      out_popped_value  <= pv_r;
      out_popped_square <= ps_r;
      out_queue_empty   <= (count_r == '0);
      out_entry_count   <= ENTRY_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        count_r <= '0;
        front_r <= '0;
      end else if (cmd.pop_take) begin
        count_r <= count_r - CNT_W'(1);
        front_r <= slot_of(front_r, CNT_W'(1));
      end else if (cmd.count_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  assign stat.op        = op_r;
  assign stat.full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.few       = (count_r < CNT_W'(2));
  assign stat.j_zero    = (j_r == '0);
  assign stat.cur_lt    = (cur_r < ram_rdata);
  assign stat.sort_more = ((i_r + CNT_W'(1)) < count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("store read and write at one address in one cycle");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_start |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("insert started on full queue");

  a_shift_j: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp_shift |-> (j_r != '0))
    else $error("shift below front entry");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_take |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not drop one entry");
endmodule

// File: tb/sorted_key_queue_tb.sv
// Self-checking testbench for sorted_key_queue: directed and random item traffic
// against an in-bench shadow of the keyed queue, with random gaps on both channels.
// Depends on skq_pkg, skq_in_if, skq_out_if and the sorted_key_queue RTL.
`timescale 1ns / 100ps

module sorted_key_queue_tb;
  import skq_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int ITEM_TARGET  = 1950;
  localparam int MAX_WAIT     = 16;
  localparam int SETTLE       = 32;
  localparam int CYCLE_LIMIT  = 10_000_000;

  localparam logic [OP_W-1:0]     OP_TOP     = '1;
  localparam logic [VALUE_W-1:0]  VALUE_MAX  = '1;
  localparam logic [SQUARE_W-1:0] SQUARE_MAX = '1;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value;
    logic [SQUARE_W-1:0] square;
    logic                empty;
    logic [ENTRY_W-1:0]  count;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  skq_in_if  in_ch ();
  skq_out_if out_ch ();

  sorted_key_queue dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  logic [KEY_W-1:0] shadow_keys [QUEUE_DEPTH];
  int               shadow_head = 0;
  int               shadow_len  = 0;

  queue_reply_t replies_due [$];
  int           mismatch_count = 0;
  int           items_sent     = 0;
  int           cycles_run     = 0;
  bit           tx_calm        = 1'b0;
  bit           rx_calm        = 1'b0;

  function automatic int ring_pos(int pos);
    return (shadow_head + pos) % QUEUE_DEPTH;
  endfunction

  function automatic queue_reply_t apply_queue_op(logic [OP_W-1:0] op,
                                                  logic [VALUE_W-1:0] value,
                                                  logic [SQUARE_W-1:0] square);
    queue_reply_t     r;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] cur;
    int               j;
    r = '0;
    r.status = ST_OK;
    key = KEY_W'(longint'(value) * BOARD_SIZE + longint'(square));
    case (op)
      OP_CLEAR: begin
        shadow_head = 0;
        shadow_len  = 0;
      end
      OP_APPEND: begin
        if (shadow_len >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[ring_pos(shadow_len)] = key;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (shadow_len >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          j = shadow_len;
          while (j > 0 && key < shadow_keys[ring_pos(j - 1)]) begin
            shadow_keys[ring_pos(j)] = shadow_keys[ring_pos(j - 1)];
            j--;
          end
          shadow_keys[ring_pos(j)] = key;
          shadow_len++;
        end
      end
      OP_SORT: begin
        for (int i = 1; i < shadow_len; i++) begin
          cur = shadow_keys[ring_pos(i)];
          j = i;
          while (j > 0 && cur < shadow_keys[ring_pos(j - 1)]) begin
            shadow_keys[ring_pos(j)] = shadow_keys[ring_pos(j - 1)];
            j--;
          end
          shadow_keys[ring_pos(j)] = cur;
        end
      end
      OP_POP: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          cur = shadow_keys[ring_pos(0)];
          r.value  = VALUE_W'(cur / BOARD_SIZE);
          r.square = SQUARE_W'(cur % BOARD_SIZE);
          shadow_head = ring_pos(1);
          shadow_len--;
        end
      end
      default: begin
      end
    endcase
    r.empty = (shadow_len == 0);
    r.count = ENTRY_W'(shadow_len);
    return r;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int fill_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(9, QUEUE_DEPTH + 2)
                                       : $urandom_range(1, 8);
  endfunction

  task automatic draw_key(output logic [VALUE_W-1:0] value,
                          output logic [SQUARE_W-1:0] square);
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      2: begin
        value  = VALUE_W'($urandom_range(0, 3));
        square = SQUARE_W'($urandom_range(0, 3));
      end
      3: begin
        value  = $urandom_range(0, 1) ? VALUE_MAX : '0;
        square = $urandom_range(0, 1) ? SQUARE_MAX : '0;
      end
      default: begin
        value  = VALUE_W'($urandom);
        square = SQUARE_W'($urandom);
      end
    endcase
  endtask

  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic [VALUE_W-1:0] value,
                           input logic [SQUARE_W-1:0] square);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.item_value  <= value;
    in_ch.item_square <= square;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    replies_due.push_back(apply_queue_op(op, value, square));
    if (op <= OP_POP) items_sent++;
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_reply();
    queue_reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t ns: unexpected result, expected none actual status %0d count %0d",
               $time, out_ch.status, out_ch.entry_count);
      mismatch_count++;
    end else begin
      want = replies_due.pop_front();
      check_field("status", 64'(want.status), 64'(out_ch.status));
      check_field("popped_value", 64'(want.value), 64'(out_ch.popped_value));
      check_field("popped_square", 64'(want.square), 64'(out_ch.popped_square));
      check_field("queue_empty", 64'(want.empty), 64'(out_ch.queue_empty));
      check_field("entry_count", 64'(want.count), 64'(out_ch.entry_count));
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      check_reply();
    end
  end

  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_empty_queue();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_SORT, '0, '0);
    send_item(OP_POP, VALUE_MAX, SQUARE_MAX);
    for (int op = OP_POP + 1; op <= OP_TOP; op++) begin
      send_item(OP_W'(op), VALUE_W'($urandom), SQUARE_W'($urandom));
    end
  endtask

  task automatic test_key_extremes();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_INSERT, VALUE_MAX, SQUARE_MAX);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_INSERT, '0, SQUARE_MAX);
    send_item(OP_INSERT, VALUE_MAX, '0);
    send_item(OP_INSERT, VALUE_MAX, SQUARE_MAX);
    send_item(OP_SORT, '0, '0);
    send_item(OP_INSERT, '0, '0);
    repeat (7) send_item(OP_POP, '0, '0);
  endtask

  task automatic test_capacity();
    logic [VALUE_W-1:0]  v;
    logic [SQUARE_W-1:0] s;
    send_item(OP_CLEAR, '0, '0);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      draw_key(v, s);
      send_item((i % 2) ? OP_INSERT : OP_APPEND, v, s);
    end
    draw_key(v, s);
    send_item(OP_APPEND, v, s);
    send_item(OP_INSERT, v, s);
    send_item(OP_SORT, '0, '0);
    repeat (4) send_item(OP_POP, '0, '0);
    repeat (5) begin
      draw_key(v, s);
      send_item(OP_INSERT, v, s);
    end
    send_item(OP_SORT, '0, '0);
    send_item(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [VALUE_W-1:0]  v;
    logic [SQUARE_W-1:0] s;
    int                  kind;
    int                  n;
    while (items_sent < ITEM_TARGET) begin
      kind    = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      case (kind)
        0, 1, 2, 3: begin
          n = fill_size();
          repeat (n) begin
            draw_key(v, s);
            send_item(($urandom_range(0, 4) == 0) ? OP_APPEND : OP_INSERT, v, s);
            if ($urandom_range(0, 15) == 0) begin
              send_item(OP_SORT, VALUE_W'($urandom), SQUARE_W'($urandom));
            end
          end
          repeat ($urandom_range(0, n + 2)) begin
            send_item(OP_POP, VALUE_W'($urandom), SQUARE_W'($urandom));
          end
        end
        4, 5: begin
          n = fill_size();
          repeat (n) begin
            draw_key(v, s);
            send_item(OP_APPEND, v, s);
          end
          send_item(OP_SORT, VALUE_W'($urandom), SQUARE_W'($urandom));
          repeat ($urandom_range(0, n + 2)) begin
            send_item(OP_POP, VALUE_W'($urandom), SQUARE_W'($urandom));
          end
        end
        6: begin
          repeat ($urandom_range(4, 20)) begin
            draw_key(v, s);
            case ($urandom_range(0, 2))
              0:       send_item(OP_POP, v, s);
              1:       send_item(OP_APPEND, v, s);
              default: send_item(OP_INSERT, v, s);
            endcase
          end
        end
        7: begin
          repeat ($urandom_range(1, 8)) begin
            send_item(OP_W'($urandom_range(0, OP_TOP)), VALUE_W'($urandom),
                      SQUARE_W'($urandom));
          end
        end
        8: send_item(OP_CLEAR, VALUE_W'($urandom), SQUARE_W'($urandom));
        default: send_item(OP_SORT, VALUE_W'($urandom), SQUARE_W'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.item_value  = '0;
    in_ch.item_square = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_key_extremes();
    test_capacity();
    test_random_traffic();
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sorted_key_queue.f
rtl/skq_pkg.sv
rtl/skq_if.sv
rtl/skq_ram.sv
rtl/skq_ctrl.sv
rtl/skq_dp.sv
rtl/sorted_key_queue.sv
tb/sorted_key_queue_tb.sv
